// ===== hdl/pkc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkc_pkg: shared types and constants of the keyword nesting checker
// keyword codes, stack entries, lexer modes, status codes and the event record
// ----------------------------------------------------------------------------
package pkc_pkg;

    // construct stack
    localparam int STACK_DEPTH = 64;
    localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STK_DW      = $clog2(STACK_DEPTH + 1);

    // event queue between lexer and stack checker, a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int              LINE_W   = 20;
    localparam logic [LINE_W-1:0] LINE_MAX = 20'hFFFFF;
    localparam int              DEPTH_OUT_W = 7;
    localparam int              WORD_W   = 30;

    // special characters
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // keyword patterns, five bits a letter, A is one
    localparam logic [WORD_W-1:0] WORD_BEGIN  = 30'({5'd2, 5'd5, 5'd7, 5'd9, 5'd14});
    localparam logic [WORD_W-1:0] WORD_END    = 30'({5'd5, 5'd14, 5'd4});
    localparam logic [WORD_W-1:0] WORD_REPEAT = 30'({5'd18, 5'd5, 5'd16, 5'd5, 5'd1, 5'd20});
    localparam logic [WORD_W-1:0] WORD_UNTIL  = 30'({5'd21, 5'd14, 5'd20, 5'd9, 5'd12});
    localparam logic [WORD_W-1:0] WORD_CASE   = 30'({5'd3, 5'd1, 5'd19, 5'd5});
    localparam logic [WORD_W-1:0] WORD_RECORD = 30'({5'd18, 5'd5, 5'd3, 5'd15, 5'd18, 5'd4});

    typedef enum logic [2:0] {
        KW_NONE   = 3'd0,
        KW_BEGIN  = 3'd1,
        KW_END    = 3'd2,
        KW_REPEAT = 3'd3,
        KW_UNTIL  = 3'd4,
        KW_CASE   = 3'd5,
        KW_RECORD = 3'd6
    } t_kw;

    typedef enum logic [1:0] {
        ENT_BEGIN  = 2'd0,
        ENT_REPEAT = 2'd1,
        ENT_CASE   = 2'd2,
        ENT_RECORD = 2'd3
    } t_entry;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_BRACE  = 3'd1,
        MODE_SQUOTE = 3'd2,
        MODE_DQUOTE = 3'd3,
        MODE_LINE   = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        ST_OK                 = 4'd0,
        ST_WORD_IN_RECORD     = 4'd1,
        ST_OPENER_OUTSIDE     = 4'd2,
        ST_RECORD_AFTER_BEGIN = 4'd3,
        ST_CLOSE_EMPTY        = 4'd4,
        ST_UNTIL_MISMATCH     = 4'd5,
        ST_END_MISMATCH       = 4'd6,
        ST_UNCLOSED           = 4'd7,
        ST_OVERFLOW           = 4'd8
    } t_status;

    // one request from lexer to stack checker
    typedef struct packed {
        t_kw               kw;        // keyword finished by this byte
        logic [LINE_W-1:0] line;      // line before this byte
        logic              line_inc;  // this byte moves to the next line
        logic              fin;       // last byte of the file
    } t_event;

    function automatic t_kw classify(logic [WORD_W-1:0] w, logic too_long);
        t_kw kw;
        kw = KW_NONE;
        if (!too_long) begin
            case (w)
                WORD_BEGIN:  kw = KW_BEGIN;
                WORD_END:    kw = KW_END;
                WORD_REPEAT: kw = KW_REPEAT;
                WORD_UNTIL:  kw = KW_UNTIL;
                WORD_CASE:   kw = KW_CASE;
                WORD_RECORD: kw = KW_RECORD;
                default:     kw = KW_NONE;
            endcase
        end
        return kw;
    endfunction

    function automatic logic [DEPTH_OUT_W-1:0] sat_depth(logic [STK_DW-1:0] d);
        logic [DEPTH_OUT_W-1:0] r;
        if (32'(d) > 32'd127) r = 7'd127;
        else                  r = DEPTH_OUT_W'(d);
        return r;
    endfunction

endpackage

// ===== hdl/pkc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkc_ram: generic single write port ram
// one write and one read address a cycle, read data registered
// ----------------------------------------------------------------------------
module pkc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pkc_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkc_lexer: front end of the keyword nesting checker
// skips comments and strings, collects words, counts lines, emits keyword and end of file events
// ----------------------------------------------------------------------------
module pkc_lexer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_char,
    input  logic            i_last,
    output logic            o_ev_valid,
    output pkc_pkg::t_event o_ev,
    input  logic            i_ev_ready
);

    import pkc_pkg::*;

    t_mode               r_mode, n_mode;
    logic [WORD_W-1:0]   r_letters, n_letters;
    logic [2:0]          r_len, n_len;
    logic                r_too_long, n_too_long;
    logic [LINE_W-1:0]   r_line, n_line;

    logic                take;
    logic                is_upper, is_lower, is_letter;
    logic [7:0]          up;
    logic [4:0]          code;
    logic                finish;
    logic                line_inc;
    t_kw                 kw;

    assign o_ready = i_ev_ready;
    assign take    = i_valid && i_ev_ready;

    assign is_upper  = (i_char >= 8'h41) && (i_char <= 8'h5A);
    assign is_lower  = (i_char >= 8'h61) && (i_char <= 8'h7A);
    assign is_letter = is_upper || is_lower;
    assign up        = is_lower ? (i_char - 8'd32) : i_char;
    assign code      = 5'(up - 8'd64);
    assign line_inc  = (i_char == CH_NL) && (r_line != LINE_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_NORMAL;
            r_letters  <= '0;
            r_len      <= '0;
            r_too_long <= 1'b0;
            r_line     <= LINE_W'(1);
        end else if (take) begin
            r_mode     <= n_mode;
            r_letters  <= n_letters;
            r_len      <= n_len;
            r_too_long <= n_too_long;
            r_line     <= n_line;
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_letters  = r_letters;
        n_len      = r_len;
        n_too_long = r_too_long;
        finish     = 1'b0;
        unique case (r_mode)
            MODE_NORMAL: begin
                if (is_letter) begin
                    if (r_len < 3'd6) begin
                        n_letters = {r_letters[WORD_W-6:0], code};
                        n_len     = r_len + 3'd1;
                    end else begin
                        n_too_long = 1'b1;
                    end
                end else begin
                    finish     = 1'b1;
                    n_letters  = '0;
                    n_len      = '0;
                    n_too_long = 1'b0;
                    if (i_char == CH_LBRACE)      n_mode = MODE_BRACE;
                    else if (i_char == CH_SQUOTE) n_mode = MODE_SQUOTE;
                    else if (i_char == CH_DQUOTE) n_mode = MODE_DQUOTE;
                    else if (i_char == CH_SLASH)  n_mode = MODE_LINE;
                end
            end
            MODE_BRACE:  if (i_char == CH_RBRACE) n_mode = MODE_NORMAL;
            MODE_SQUOTE: if (i_char == CH_SQUOTE) n_mode = MODE_NORMAL;
            MODE_DQUOTE: if (i_char == CH_DQUOTE) n_mode = MODE_NORMAL;
            MODE_LINE:   if (i_char == CH_NL)     n_mode = MODE_NORMAL;
            default:     n_mode = MODE_NORMAL;
        endcase

        // word ended by a separator, or the word still open at end of file
        if (finish)      kw = classify(r_letters, r_too_long);
        else if (i_last) kw = classify(n_letters, n_too_long);
        else             kw = KW_NONE;

        n_line = r_line + LINE_W'(line_inc);

        if (i_last) begin
            n_mode     = MODE_NORMAL;
            n_letters  = '0;
            n_len      = '0;
            n_too_long = 1'b0;
            n_line     = LINE_W'(1);
        end
    end

    assign o_ev_valid    = take && ((kw != KW_NONE) || i_last);
    assign o_ev.kw       = kw;
    assign o_ev.line     = r_line;
    assign o_ev.line_inc = line_inc;
    assign o_ev.fin      = i_last;

endmodule

// ===== hdl/pkc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkc_queue: short event queue between lexer and stack checker
// register based fifo, lets either side stall on its own
// ----------------------------------------------------------------------------
module pkc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pkc_pkg::t_event i_data,
    output logic            o_full,
    output logic            o_valid,
    output pkc_pkg::t_event o_data,
    input  logic            i_pop
);

    import pkc_pkg::*;

    t_event               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr, r_rd;
    logic [QUEUE_CW-1:0]  r_count;
    logic                 do_push, do_pop;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + QUEUE_AW'(1);
            if (do_pop)  r_rd <= r_rd + QUEUE_AW'(1);
            r_count <= r_count + QUEUE_CW'(do_push) - QUEUE_CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hdl/pkc_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkc_check: back end of the keyword nesting checker
// construct stack with top in a register, error latch and result register
// ----------------------------------------------------------------------------
module pkc_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_ev_valid,
    input  pkc_pkg::t_event                     i_ev,
    output logic                                o_ev_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [3:0]                          o_status,
    output logic [pkc_pkg::LINE_W-1:0]          o_line,
    output logic [2:0]                          o_kw,
    output logic [pkc_pkg::DEPTH_OUT_W-1:0]     o_depth
);

    import pkc_pkg::*;

    logic [STK_DW-1:0]      r_depth, n_depth;
    t_entry                 r_top, n_top;
    t_entry                 r_byp, n_byp;
    logic                   r_use_byp, n_use_byp;
    logic                   r_begin_seen, n_begin_seen;
    logic                   r_in_record, n_in_record;
    logic                   r_err, n_err;
    logic                   r_out_valid, n_out_valid;
    t_status                r_out_status, n_out_status;
    logic [LINE_W-1:0]      r_out_line, n_out_line;
    t_kw                    r_out_kw, n_out_kw;
    logic [DEPTH_OUT_W-1:0] r_out_depth, n_out_depth;

    logic                   take;
    logic                   full, empty;
    logic                   push, pop, fail;
    t_entry                 push_ent;
    t_status                fail_status;
    t_entry                 below;
    logic [1:0]             ram_rdata;
    logic [STK_DW-1:0]      rd_full, wr_full;

    assign take  = i_ev_valid && (!r_out_valid || i_ready);
    assign full  = (r_depth == STK_DW'(STACK_DEPTH));
    assign empty = (r_depth == '0);
    assign below = r_use_byp ? r_byp : t_entry'(ram_rdata);

    // entries below the top live in ram, read address follows next depth
    assign rd_full = n_depth - STK_DW'(2);
    assign wr_full = r_depth - STK_DW'(1);

    pkc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (push && !empty),
        .i_waddr (wr_full[STK_AW-1:0]),
        .i_wdata (r_top),
        .i_raddr (rd_full[STK_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth      <= '0;
            r_use_byp    <= 1'b0;
            r_begin_seen <= 1'b0;
            r_in_record  <= 1'b0;
            r_err        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_depth      <= n_depth;
            r_use_byp    <= n_use_byp;
            r_begin_seen <= n_begin_seen;
            r_in_record  <= n_in_record;
            r_err        <= n_err;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_byp        <= n_byp;
        r_out_status <= n_out_status;
        r_out_line   <= n_out_line;
        r_out_kw     <= n_out_kw;
        r_out_depth  <= n_out_depth;
    end

    always_comb begin
        push        = 1'b0;
        pop         = 1'b0;
        fail        = 1'b0;
        push_ent    = ENT_BEGIN;
        fail_status = ST_OK;
        n_begin_seen = r_begin_seen;
        n_in_record  = r_in_record;
        n_err        = r_err;

        if (take && !r_err && (i_ev.kw != KW_NONE)) begin
            if (r_in_record && (i_ev.kw != KW_END)) begin
                fail        = 1'b1;
                fail_status = ST_WORD_IN_RECORD;
            end else begin
                unique case (i_ev.kw) inside
                    KW_BEGIN: begin
                        n_begin_seen = 1'b1;
                        if (full) begin
                            fail        = 1'b1;
                            fail_status = ST_OVERFLOW;
                        end else begin
                            push     = 1'b1;
                            push_ent = ENT_BEGIN;
                        end
                    end
                    KW_REPEAT, KW_CASE: begin
                        if (empty) begin
                            fail        = 1'b1;
                            fail_status = ST_OPENER_OUTSIDE;
                        end else if (full) begin
                            fail        = 1'b1;
                            fail_status = ST_OVERFLOW;
                        end else begin
                            push     = 1'b1;
                            push_ent = (i_ev.kw == KW_REPEAT) ? ENT_REPEAT : ENT_CASE;
                        end
                    end
                    KW_RECORD: begin
                        n_in_record = 1'b1;
                        if (r_begin_seen) begin
                            fail        = 1'b1;
                            fail_status = ST_RECORD_AFTER_BEGIN;
                        end else if (full) begin
                            fail        = 1'b1;
                            fail_status = ST_OVERFLOW;
                        end else begin
                            push     = 1'b1;
                            push_ent = ENT_RECORD;
                        end
                    end
                    KW_UNTIL: begin
                        if (empty) begin
                            fail        = 1'b1;
                            fail_status = ST_CLOSE_EMPTY;
                        end else if (r_top != ENT_REPEAT) begin
                            fail        = 1'b1;
                            fail_status = ST_UNTIL_MISMATCH;
                        end else begin
                            pop = 1'b1;
                        end
                    end
                    KW_END: begin
                        if (empty) begin
                            fail        = 1'b1;
                            fail_status = ST_CLOSE_EMPTY;
                        end else if (r_top == ENT_REPEAT) begin
                            fail        = 1'b1;
                            fail_status = ST_END_MISMATCH;
                        end else begin
                            if (r_top == ENT_RECORD) n_in_record = 1'b0;
                            pop = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end

        // stack update, top of stack held in a register
        n_depth   = r_depth;
        n_top     = r_top;
        n_byp     = r_byp;
        n_use_byp = r_use_byp;
        if (push) begin
            n_depth   = r_depth + STK_DW'(1);
            n_top     = push_ent;
            n_byp     = r_top;
            n_use_byp = 1'b1;
        end else if (pop) begin
            n_depth   = r_depth - STK_DW'(1);
            n_top     = below;
            n_use_byp = 1'b0;
        end

        // result register
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_line   = r_out_line;
        n_out_kw     = r_out_kw;
        n_out_depth  = r_out_depth;
        if (fail) begin
            n_err        = 1'b1;
            n_out_valid  = 1'b1;
            n_out_status = fail_status;
            n_out_line   = i_ev.line;
            n_out_kw     = i_ev.kw;
            n_out_depth  = sat_depth(r_depth);
        end else if (take && !r_err && i_ev.fin) begin
            n_out_valid  = 1'b1;
            n_out_status = (n_depth != '0) ? ST_UNCLOSED : ST_OK;
            n_out_line   = i_ev.line + LINE_W'(i_ev.line_inc);
            n_out_kw     = KW_NONE;
            n_out_depth  = sat_depth(n_depth);
        end

        // end of file clears the checker state
        if (take && i_ev.fin) begin
            n_depth      = '0;
            n_use_byp    = 1'b0;
            n_begin_seen = 1'b0;
            n_in_record  = 1'b0;
            n_err        = 1'b0;
        end
    end

    assign o_ev_pop = take;
    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_line   = r_out_line;
    assign o_kw     = r_out_kw;
    assign o_depth  = r_out_depth;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_depth) <= STACK_DEPTH)
        else $error("stack depth beyond capacity");

    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_ev.fin) |=> (r_depth == '0) && !r_err && !r_in_record)
        else $error("end of file left checker state behind");

    a_silent_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_err) |=> !r_out_valid)
        else $error("result produced after an error was latched");

    a_fail_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fail |=> r_out_valid && (r_out_status != ST_OK) && (r_out_status != ST_UNCLOSED))
        else $error("error not reported");

endmodule

// ===== hdl/pascal_keyword_nesting_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pascal_keyword_nesting_checker: keyword nesting checker for pascal-like text
// lexer front end, event queue and construct stack back end
// ----------------------------------------------------------------------------
// The checker takes one byte of source text per clock while the event queue
// is not full; a result passes from the lexer into the event queue, then
// through the stack checker into the result register. The rate is set by the
// stack checker, which handles one keyword event per cycle while its result
// register is empty or being read: the top of the construct stack sits in a
// register and the entries below it in a ram with one write and one read port
// and registered read, addressed from the next depth so a push or pop can
// follow every cycle. The lexer only sends a request to the checker when a
// keyword is finished or at the last byte, so the four-entry queue between
// them rarely fills. At most one result is produced per file: the first
// error, or an ok / unclosed result at the byte marked tlast; bytes after an
// error are dropped until that last byte. The stack ram needs no clearing
// pass after reset, only entries below the current depth are ever read.
// ----------------------------------------------------------------------------
module pascal_keyword_nesting_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // source text requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // last byte of the file
    // result requests
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [3:0] status, [23:4] line_number,
                                        // [26:24] keyword, [33:27] open_depth,
                                        // [39:34] zero
);

    import pkc_pkg::*;

    // lexer to queue
    logic   lex_ev_valid;
    t_event lex_ev;
    logic   q_full;

    // queue to stack checker
    logic   q_valid;
    t_event q_ev;
    logic   q_pop;

    // result fields
    logic [3:0]             res_status;
    logic [LINE_W-1:0]      res_line;
    logic [2:0]             res_kw;
    logic [DEPTH_OUT_W-1:0] res_depth;

    // front: comment and string skipping, word collection, line count
    pkc_lexer u_lexer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_char     (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .o_ev_valid (lex_ev_valid),
        .o_ev       (lex_ev),
        .i_ev_ready (!q_full)
    );

    // keyword events waiting for the stack checker
    pkc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (lex_ev_valid),
        .i_data  (lex_ev),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_ev),
        .i_pop   (q_pop)
    );

    // back: nesting rules, construct stack, first error latch, result register
    pkc_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev_valid (q_valid),
        .i_ev       (q_ev),
        .o_ev_pop   (q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_status   (res_status),
        .o_line     (res_line),
        .o_kw       (res_kw),
        .o_depth    (res_depth)
    );

    assign m_axis_tdata = {6'd0, res_depth, res_kw, res_line, res_status};

endmodule
